// File: sv/lsbs_pkg.sv
// Shared types, codes and constants of the LED strip turn/brake sequencer.
package lsbs_pkg;

  // strip geometry
  localparam int LED_COUNT  = 32;
  localparam int REAR_SPLIT = 25;
  localparam int IDX_W      = $clog2(LED_COUNT);
  localparam int POS_W      = 6;

  // timer constants in milliseconds
  localparam logic [31:0] REFRESH_MS = 32'd5000;
  localparam logic [31:0] BRAKE_MS   = 32'd3500;
  localparam logic [31:0] RELEASE_MS = 32'd250;
  localparam logic [31:0] NEVER_MS   = 32'hFFFF_FFFF;

  // global strip levels
  localparam logic [4:0] LEVEL_REAR   = 5'd1;
  localparam logic [4:0] LEVEL_NORMAL = 5'd10;

  // configuration register reset values
  localparam logic [23:0] RST_SWEEP_COLOR  = 24'd16744448;
  localparam logic [7:0]  RST_SWEEP_BRIGHT = 8'd31;
  localparam logic [15:0] RST_SWEEP_DUR    = 16'd3000;
  localparam logic [15:0] RST_STEP_INT     = 16'd20;
  localparam logic [15:0] RST_END_PAUSE    = 16'd300;
  localparam logic [7:0]  RST_BRAKE_BRIGHT = 8'd31;
  localparam logic [7:0]  RST_REAR_LEVEL   = 8'd64;
  localparam logic [7:0]  RST_REAR_BRIGHT  = 8'd8;

  // request codes
  typedef enum logic [2:0] {
    REQ_TICK    = 3'd0,
    REQ_SWEEP   = 3'd1,
    REQ_BRAKE   = 3'd2,
    REQ_RELEASE = 3'd3,
    REQ_REAR    = 3'd4
  } req_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_SWEEP_COLOR  = 3'd0,
    CFG_SWEEP_BRIGHT = 3'd1,
    CFG_SWEEP_DUR    = 3'd2,
    CFG_STEP_INT     = 3'd3,
    CFG_END_PAUSE    = 3'd4,
    CFG_BRAKE_BRIGHT = 3'd5,
    CFG_REAR_LEVEL   = 3'd6,
    CFG_REAR_BRIGHT  = 3'd7
  } cfg_idx_t;

  // datapath actions issued by the controller
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_SWEEP_GO,
    ACT_BRAKE,
    ACT_RELEASE,
    ACT_REAR,
    ACT_REFRESH,
    ACT_EXPIRE,
    ACT_SWEEP_STOP,
    ACT_STEP,
    ACT_WRAP,
    ACT_CLR_PEND
  } act_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_TICK_PEND,
    ST_STEP,
    ST_EMIT_REAR,
    ST_EMIT_FILL,
    ST_EMIT_SWEEP,
    ST_WRAP
  } state_t;

  // input beat
  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] now_ms;
  } in_beat_t;

  // result beat, one pixel
  typedef struct packed {
    logic [5:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] pixel_brightness;
    logic [4:0] frame_level;
    logic       last;
  } out_beat_t;

  // controller to datapath
  typedef struct packed {
    act_t act;
    logic emit;
    logic emit_sweep;
    logic emit_rear;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] req;
    logic       rear_mode;
    logic       pending;
    logic       sweeping;
    logic       braking;
    logic       refresh_due;
    logic       brake_due;
    logic       sweep_over;
    logic       step_due;
    logic       emit_last;
  } sts_t;

endpackage

// File: sv/lsbs_ctrl.sv
// Controller state machine of the LED strip turn/brake sequencer.
module lsbs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  lsbs_pkg::sts_t  sts,
  output lsbs_pkg::cmd_t  cmd
);

  lsbs_pkg::state_t state_r, state_nxt;

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lsbs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    cmd.act        = lsbs_pkg::ACT_NONE;
    cmd.emit       = 1'b0;
    cmd.emit_sweep = 1'b0;
    cmd.emit_rear  = 1'b0;
    busy           = (state_r != lsbs_pkg::ST_IDLE);
    case (state_r)
      lsbs_pkg::ST_IDLE: begin
        if (start) begin
          cmd.act   = lsbs_pkg::ACT_LOAD;
          state_nxt = lsbs_pkg::ST_DECODE;
        end
      end
      lsbs_pkg::ST_DECODE: begin
        state_nxt = lsbs_pkg::ST_IDLE;
        case (sts.req)
          lsbs_pkg::REQ_TICK: begin
            if (sts.rear_mode) begin
              if (sts.refresh_due) begin
                cmd.act   = lsbs_pkg::ACT_REFRESH;
                state_nxt = lsbs_pkg::ST_EMIT_REAR;
              end
            end else begin
              if (sts.brake_due) begin
                cmd.act = lsbs_pkg::ACT_EXPIRE;
              end
              state_nxt = lsbs_pkg::ST_TICK_PEND;
            end
          end
          lsbs_pkg::REQ_SWEEP: begin
            if (!sts.sweeping) begin
              cmd.act = lsbs_pkg::ACT_SWEEP_GO;
            end
          end
          lsbs_pkg::REQ_BRAKE: begin
            cmd.act = lsbs_pkg::ACT_BRAKE;
          end
          lsbs_pkg::REQ_RELEASE: begin
            if (sts.braking) begin
              cmd.act = lsbs_pkg::ACT_RELEASE;
            end
          end
          lsbs_pkg::REQ_REAR: begin
            cmd.act   = lsbs_pkg::ACT_REAR;
            state_nxt = lsbs_pkg::ST_EMIT_REAR;
          end
          default: begin
            cmd.act = lsbs_pkg::ACT_NONE;
          end
        endcase
      end
      lsbs_pkg::ST_TICK_PEND: begin
        if (!sts.pending) begin
          state_nxt = lsbs_pkg::ST_IDLE;
        end else if (sts.sweeping) begin
          if (sts.sweep_over) begin
            cmd.act = lsbs_pkg::ACT_SWEEP_STOP;
          end
          state_nxt = lsbs_pkg::ST_STEP;
        end else begin
          cmd.act   = lsbs_pkg::ACT_CLR_PEND;
          state_nxt = lsbs_pkg::ST_EMIT_FILL;
        end
      end
      lsbs_pkg::ST_STEP: begin
        if (sts.step_due) begin
          cmd.act   = lsbs_pkg::ACT_STEP;
          state_nxt = lsbs_pkg::ST_EMIT_SWEEP;
        end else begin
          state_nxt = lsbs_pkg::ST_IDLE;
        end
      end
      lsbs_pkg::ST_EMIT_REAR: begin
        cmd.emit      = 1'b1;
        cmd.emit_rear = 1'b1;
        if (sts.emit_last) begin
          state_nxt = lsbs_pkg::ST_IDLE;
        end
      end
      lsbs_pkg::ST_EMIT_FILL: begin
        cmd.emit = 1'b1;
        if (sts.emit_last) begin
          state_nxt = lsbs_pkg::ST_IDLE;
        end
      end
      lsbs_pkg::ST_EMIT_SWEEP: begin
        cmd.emit       = 1'b1;
        cmd.emit_sweep = 1'b1;
        if (sts.emit_last) begin
          state_nxt = lsbs_pkg::ST_WRAP;
        end
      end
      lsbs_pkg::ST_WRAP: begin
        cmd.act   = lsbs_pkg::ACT_WRAP;
        state_nxt = lsbs_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = lsbs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/lsbs_dpath.sv
// Datapath of the LED strip turn/brake sequencer: frames, timers, flags, output beat.
module lsbs_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  lsbs_pkg::in_beat_t  in_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_idx,
  input  logic [23:0]         cfg_data,
  input  lsbs_pkg::cmd_t      cmd,
  output lsbs_pkg::sts_t      sts,
  output logic                out_valid,
  output lsbs_pkg::out_beat_t out_data
);

  localparam int IDX_W = lsbs_pkg::IDX_W;
  localparam int PW    = lsbs_pkg::POS_W + 1;

  // latched request
  logic [2:0]  req_r, req_nxt;
  logic [31:0] now_r, now_nxt;

  // configuration registers
  logic [23:0] sweep_color_r, sweep_color_nxt;
  logic [7:0]  sweep_bright_r, sweep_bright_nxt;
  logic [15:0] sweep_dur_r, sweep_dur_nxt;
  logic [15:0] step_int_r, step_int_nxt;
  logic [15:0] end_pause_r, end_pause_nxt;
  logic [7:0]  brake_bright_r, brake_bright_nxt;
  logic [7:0]  rear_level_r, rear_level_nxt;
  logic [7:0]  rear_bright_r, rear_bright_nxt;

  // frames: fill frame is one value below the split and one at and past it
  logic [31:0] fill_color_r, fill_color_nxt;
  logic [31:0] fill_lo_r, fill_lo_nxt;
  logic [31:0] fill_hi_r, fill_hi_nxt;
  logic [31:0] sweep_frame_r   [lsbs_pkg::LED_COUNT];
  logic [31:0] sweep_frame_nxt [lsbs_pkg::LED_COUNT];

  // timers and flags
  logic [lsbs_pkg::POS_W-1:0] sweep_pos_r, sweep_pos_nxt;
  logic [31:0] refresh_r, refresh_nxt;
  logic [31:0] brake_end_r, brake_end_nxt;
  logic [31:0] sweep_start_r, sweep_start_nxt;
  logic [31:0] step_stamp_r, step_stamp_nxt;
  logic        pending_r, pending_nxt;
  logic        braking_r, braking_nxt;
  logic        sweeping_r, sweeping_nxt;
  logic        rear_mode_r, rear_mode_nxt;

  // emission
  logic [IDX_W-1:0]    cnt_r, cnt_nxt;
  logic                out_vld_r, out_vld_nxt;
  lsbs_pkg::out_beat_t out_beat_r, out_beat_nxt;

  logic [31:0] refresh_lim, sweep_lim, step_lim, fill_px, src_px, mid_color;
  logic        emit_last;

  // deadline sums, all wrapping modulo 2^32
  assign refresh_lim = refresh_r + lsbs_pkg::REFRESH_MS;
  assign sweep_lim   = sweep_start_r + {16'd0, sweep_dur_r};
  assign step_lim    = step_stamp_r + {16'd0, step_int_r};
  assign emit_last   = (cnt_r == IDX_W'(lsbs_pkg::LED_COUNT - 1));

  // status toward the controller
  always_comb begin
    sts.req         = req_r;
    sts.rear_mode   = rear_mode_r;
    sts.pending     = pending_r;
    sts.sweeping    = sweeping_r;
    sts.braking     = braking_r;
    sts.refresh_due = (refresh_lim < now_r);
    sts.brake_due   = (brake_end_r < now_r);
    sts.sweep_over  = (sweep_lim < now_r);
    sts.step_due    = (step_lim < now_r);
    sts.emit_last   = emit_last;
  end

  // pick the pixel for the current beat
  assign fill_px   = (PW'(cnt_r) < PW'(lsbs_pkg::REAR_SPLIT)) ? fill_lo_r : fill_hi_r;
  assign src_px    = cmd.emit_sweep ? sweep_frame_r[cnt_r] : fill_px;
  assign mid_color = {rear_bright_r, rear_level_r, fill_color_r[15:0]};

  // next state of the datapath
  always_comb begin
    req_nxt          = req_r;
    now_nxt          = now_r;
    sweep_color_nxt  = sweep_color_r;
    sweep_bright_nxt = sweep_bright_r;
    sweep_dur_nxt    = sweep_dur_r;
    step_int_nxt     = step_int_r;
    end_pause_nxt    = end_pause_r;
    brake_bright_nxt = brake_bright_r;
    rear_level_nxt   = rear_level_r;
    rear_bright_nxt  = rear_bright_r;
    fill_color_nxt   = fill_color_r;
    fill_lo_nxt      = fill_lo_r;
    fill_hi_nxt      = fill_hi_r;
    sweep_frame_nxt  = sweep_frame_r;
    sweep_pos_nxt    = sweep_pos_r;
    refresh_nxt      = refresh_r;
    brake_end_nxt    = brake_end_r;
    sweep_start_nxt  = sweep_start_r;
    step_stamp_nxt   = step_stamp_r;
    pending_nxt      = pending_r;
    braking_nxt      = braking_r;
    sweeping_nxt     = sweeping_r;
    rear_mode_nxt    = rear_mode_r;
    cnt_nxt          = cnt_r;
    out_vld_nxt      = 1'b0;
    out_beat_nxt     = out_beat_r;

    // apply the action
    case (cmd.act)
      lsbs_pkg::ACT_LOAD: begin
        req_nxt = in_data.req_type;
        now_nxt = in_data.now_ms;
      end
      lsbs_pkg::ACT_SWEEP_GO: begin
        sweeping_nxt    = 1'b1;
        sweep_start_nxt = now_r;
        step_stamp_nxt  = now_r;
        pending_nxt     = 1'b1;
        sweep_pos_nxt   = '0;
      end
      lsbs_pkg::ACT_BRAKE: begin
        pending_nxt    = 1'b1;
        braking_nxt    = 1'b1;
        brake_end_nxt  = now_r + lsbs_pkg::BRAKE_MS;
        fill_color_nxt = {brake_bright_r, 8'hFF, fill_color_r[15:0]};
        fill_lo_nxt    = fill_color_nxt;
        fill_hi_nxt    = fill_color_nxt;
      end
      lsbs_pkg::ACT_RELEASE: begin
        pending_nxt   = 1'b1;
        braking_nxt   = 1'b0;
        brake_end_nxt = now_r + lsbs_pkg::RELEASE_MS;
      end
      lsbs_pkg::ACT_REAR: begin
        rear_mode_nxt  = 1'b1;
        fill_lo_nxt    = mid_color;
        fill_color_nxt = {rear_bright_r, rear_level_r, rear_level_r, rear_level_r};
        fill_hi_nxt    = fill_color_nxt;
        refresh_nxt    = now_r;
      end
      lsbs_pkg::ACT_REFRESH: begin
        refresh_nxt = now_r;
      end
      lsbs_pkg::ACT_EXPIRE: begin
        pending_nxt    = 1'b1;
        brake_end_nxt  = lsbs_pkg::NEVER_MS;
        braking_nxt    = 1'b0;
        fill_color_nxt = {16'd0, fill_color_r[15:0]};
        fill_lo_nxt    = fill_color_nxt;
        fill_hi_nxt    = fill_color_nxt;
      end
      lsbs_pkg::ACT_SWEEP_STOP: begin
        sweeping_nxt  = 1'b0;
        sweep_pos_nxt = '0;
      end
      lsbs_pkg::ACT_STEP: begin
        step_stamp_nxt = now_r;
        sweep_frame_nxt[sweep_pos_r[IDX_W-1:0]] = {sweep_bright_r, sweep_color_r};
        sweep_pos_nxt  = sweep_pos_r + 1'b1;
      end
      lsbs_pkg::ACT_WRAP: begin
        if (PW'(sweep_pos_r) >= PW'(lsbs_pkg::LED_COUNT)) begin
          sweep_pos_nxt = '0;
          for (int i = 0; i < lsbs_pkg::LED_COUNT; i++) begin
            sweep_frame_nxt[i] = fill_color_r;
          end
          step_stamp_nxt = step_stamp_r + {16'd0, end_pause_r};
        end
      end
      lsbs_pkg::ACT_CLR_PEND: begin
        pending_nxt = 1'b0;
      end
      default: begin
        pending_nxt = pending_r;
      end
    endcase

    // drive one pixel beat per emit cycle
    if (cmd.emit) begin
      out_vld_nxt                   = 1'b1;
      out_beat_nxt.pixel_index      = 6'(cnt_r);
      out_beat_nxt.red              = src_px[23:16];
      out_beat_nxt.green            = src_px[15:8];
      out_beat_nxt.blue             = src_px[7:0];
      out_beat_nxt.pixel_brightness = src_px[31:24];
      out_beat_nxt.frame_level      = cmd.emit_rear ? lsbs_pkg::LEVEL_REAR
                                                    : lsbs_pkg::LEVEL_NORMAL;
      out_beat_nxt.last             = emit_last;
      cnt_nxt                       = emit_last ? '0 : cnt_r + 1'b1;
    end

    // configuration writes
    if (cfg_we) begin
      case (lsbs_pkg::cfg_idx_t'(cfg_idx))
        lsbs_pkg::CFG_SWEEP_COLOR:  sweep_color_nxt = cfg_data;
        lsbs_pkg::CFG_SWEEP_BRIGHT: begin
          sweep_bright_nxt = cfg_data[7:0];
          pending_nxt      = 1'b1;
        end
        lsbs_pkg::CFG_SWEEP_DUR:    sweep_dur_nxt    = cfg_data[15:0];
        lsbs_pkg::CFG_STEP_INT:     step_int_nxt     = cfg_data[15:0];
        lsbs_pkg::CFG_END_PAUSE:    end_pause_nxt    = cfg_data[15:0];
        lsbs_pkg::CFG_BRAKE_BRIGHT: brake_bright_nxt = cfg_data[7:0];
        lsbs_pkg::CFG_REAR_LEVEL:   rear_level_nxt   = cfg_data[7:0];
        lsbs_pkg::CFG_REAR_BRIGHT:  rear_bright_nxt  = cfg_data[7:0];
        default:                    rear_bright_nxt  = rear_bright_r;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_color_r  <= lsbs_pkg::RST_SWEEP_COLOR;
      sweep_bright_r <= lsbs_pkg::RST_SWEEP_BRIGHT;
      sweep_dur_r    <= lsbs_pkg::RST_SWEEP_DUR;
      step_int_r     <= lsbs_pkg::RST_STEP_INT;
      end_pause_r    <= lsbs_pkg::RST_END_PAUSE;
      brake_bright_r <= lsbs_pkg::RST_BRAKE_BRIGHT;
      rear_level_r   <= lsbs_pkg::RST_REAR_LEVEL;
      rear_bright_r  <= lsbs_pkg::RST_REAR_BRIGHT;
      fill_color_r   <= '0;
      fill_lo_r      <= '0;
      fill_hi_r      <= '0;
      for (int i = 0; i < lsbs_pkg::LED_COUNT; i++) begin
        sweep_frame_r[i] <= '0;
      end
      sweep_pos_r    <= '0;
      refresh_r      <= '0;
      brake_end_r    <= lsbs_pkg::NEVER_MS;
      sweep_start_r  <= '0;
      step_stamp_r   <= '0;
      pending_r      <= 1'b0;
      braking_r      <= 1'b0;
      sweeping_r     <= 1'b0;
      rear_mode_r    <= 1'b0;
      cnt_r          <= '0;
      out_vld_r      <= 1'b0;
    end else begin
      sweep_color_r  <= sweep_color_nxt;
      sweep_bright_r <= sweep_bright_nxt;
      sweep_dur_r    <= sweep_dur_nxt;
      step_int_r     <= step_int_nxt;
      end_pause_r    <= end_pause_nxt;
      brake_bright_r <= brake_bright_nxt;
      rear_level_r   <= rear_level_nxt;
      rear_bright_r  <= rear_bright_nxt;
      fill_color_r   <= fill_color_nxt;
      fill_lo_r      <= fill_lo_nxt;
      fill_hi_r      <= fill_hi_nxt;
      sweep_frame_r  <= sweep_frame_nxt;
      sweep_pos_r    <= sweep_pos_nxt;
      refresh_r      <= refresh_nxt;
      brake_end_r    <= brake_end_nxt;
      sweep_start_r  <= sweep_start_nxt;
      step_stamp_r   <= step_stamp_nxt;
      pending_r      <= pending_nxt;
      braking_r      <= braking_nxt;
      sweeping_r     <= sweeping_nxt;
      rear_mode_r    <= rear_mode_nxt;
      cnt_r          <= cnt_nxt;
      out_vld_r      <= out_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    now_r      <= now_nxt;
    out_beat_r <= out_beat_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_beat_r;

endmodule

// File: sv/led_strip_turn_brake_sequencer.sv
// Top level of the LED strip turn/brake sequencer: controller plus datapath.
//
// A request is taken when start is high and busy is low. Requests that only
// change state (start sweep, brake, release, unknown codes) pass through the
// decode state and then return to idle. A request that emits a frame streams
// LED_COUNT pixel beats on out_data, one per cycle with out_valid high for
// each, the last one flagged; the receiver cannot stall and must take every
// beat. A frame-emitting tick stays busy through decode, the pending check and
// the fill emit (fill frame), through decode and the rear emit (rear refresh), or
// through decode, the pending check, the step write, the sweep emit and the wrap
// check (sweep frame): the single pixel read port walks the frame one beat per
// cycle and each state makes at most one deadline compare. A rear mode request
// is busy through decode and the rear emit. After a fill or rear frame the final
// beat still sits on the output register when the next request can be accepted.
// Configuration writes take effect at the write edge and are meant to be issued
// while busy is low and no beats are outstanding.
module led_strip_turn_brake_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  lsbs_pkg::in_beat_t  in_data,
  output logic                out_valid,
  output lsbs_pkg::out_beat_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_idx,
  input  logic [23:0]         cfg_data
);

  lsbs_pkg::cmd_t cmd;
  lsbs_pkg::sts_t sts;

  lsbs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  lsbs_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // an accepted request always makes the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request accepted but block not busy");

  // a frame ends with its last beat and nothing follows directly
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |=> !out_valid)
    else $error("beat right after the last pixel of a frame");

  // frame beats are contiguous
  a_frame_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |=> out_valid)
    else $error("frame interrupted before its last pixel");

  // every frame starts at pixel zero
  a_frame_head: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> out_data.pixel_index == 6'd0)
    else $error("frame does not start at pixel zero");

endmodule

// File: sim/testbench.sv
// Self-checking testbench of the LED strip turn/brake sequencer with a pixel-level predictor.
module testbench;
  import lsbs_pkg::*;

  localparam int          DRAIN_CYCLES = LED_COUNT + 8;
  localparam int          SETTLE_LIMIT = 20000;
  localparam int          MAX_REPORTS  = 10;
  localparam logic [2:0]  REQ_UNK_LO   = 3'd5;
  localparam logic [2:0]  REQ_UNK_HI   = 3'd7;

  // how a directed row is checked
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_FLAT
  } chk_t;

  typedef struct packed {
    logic [2:0]  req;
    logic [31:0] now;
    chk_t        chk;
    logic [31:0] flat;
    logic [4:0]  lvl;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_beat_t  in_data;
  logic      out_valid;
  out_beat_t out_data;
  logic      cfg_we;
  logic [2:0] cfg_idx;
  logic [23:0] cfg_data;

  // predicted strip state
  logic [31:0] fill_buf [LED_COUNT];
  logic [31:0] sweep_buf [LED_COUNT];
  logic [31:0] fill_px;
  logic [5:0]  sweep_idx;
  logic [31:0] refresh_at, brake_stop, sweep_t0, step_t;
  logic        pend, brake_on, sweep_on, rear_on;

  // predicted register file
  logic [23:0] r_color;
  logic [7:0]  r_sbright, r_bbright, r_rlevel, r_rbright;
  logic [15:0] r_dur, r_step, r_pause;

  out_beat_t   frame_px [$];
  out_beat_t   due_px [$];
  dir_row_t    script [$];
  logic [31:0] clock_ms;
  int          mismatches;
  int          rear_from;

  led_strip_turn_brake_sequencer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("led_strip_turn_brake_sequencer: mismatch");
    $finish;
  end

  // Build one pixel beat from a packed pixel word.
  function automatic out_beat_t pixel_beat(int i, logic [31:0] px, logic [4:0] level);
    out_beat_t o;
    o.pixel_index      = 6'(i);
    o.red              = px[23:16];
    o.green            = px[15:8];
    o.blue             = px[7:0];
    o.pixel_brightness = px[31:24];
    o.frame_level      = level;
    o.last             = (i == LED_COUNT - 1);
    return o;
  endfunction

  function automatic dir_row_t row(logic [2:0] req, logic [31:0] now, chk_t chk,
                                   logic [31:0] flat = 32'h0, logic [4:0] lvl = 5'd0);
    dir_row_t r;
    r.req  = req;
    r.now  = now;
    r.chk  = chk;
    r.flat = flat;
    r.lvl  = lvl;
    return r;
  endfunction

  // Queue one whole frame of predicted pixels.
  task automatic emit_frame(input bit from_sweep, input logic [4:0] level);
    for (int i = 0; i < LED_COUNT; i++)
      frame_px.push_back(pixel_beat(i, from_sweep ? sweep_buf[i] : fill_buf[i], level));
  endtask

  // Advance the predicted strip by one event and collect the pixels it emits.
  task automatic advance_strip(input in_beat_t b);
    logic [31:0] now;
    frame_px.delete();
    now = b.now_ms;
    case (b.req_type)
      REQ_TICK: begin
        if (rear_on) begin
          // rear mode only refreshes periodically
          if (refresh_at + REFRESH_MS < now) begin
            emit_frame(1'b0, LEVEL_REAR);
            refresh_at = now;
          end
        end else begin
          // drop the brake once its deadline has passed
          if (brake_stop < now) begin
            pend       = 1'b1;
            brake_stop = NEVER_MS;
            brake_on   = 1'b0;
            fill_px    = fill_px & 32'h0000_FFFF;
            foreach (fill_buf[i]) fill_buf[i] = fill_px;
          end
          if (pend) begin
            if (sweep_on) begin
              if (sweep_t0 + r_dur < now) begin
                sweep_on  = 1'b0;
                sweep_idx = '0;
              end
              // the step check still runs on the tick that ends the sweep
              if (step_t + r_step < now) begin
                step_t = now;
                sweep_buf[int'(sweep_idx) % LED_COUNT] = {r_sbright, r_color};
                sweep_idx = sweep_idx + 6'd1;
                emit_frame(1'b1, LEVEL_NORMAL);
                // wrap at strip end: clear after the frame went out
                if (sweep_idx >= LED_COUNT) begin
                  sweep_idx = '0;
                  foreach (sweep_buf[i]) sweep_buf[i] = fill_px;
                  step_t = step_t + r_pause;
                end
              end
            end else begin
              emit_frame(1'b0, LEVEL_NORMAL);
              pend = 1'b0;
            end
          end
        end
      end
      REQ_SWEEP: begin
        if (!sweep_on) begin
          sweep_on  = 1'b1;
          sweep_t0  = now;
          step_t    = now;
          pend      = 1'b1;
          sweep_idx = '0;
        end
      end
      REQ_BRAKE: begin
        pend       = 1'b1;
        brake_on   = 1'b1;
        brake_stop = now + BRAKE_MS;
        fill_px    = {r_bbright, 8'hFF, fill_px[15:0]};
        foreach (fill_buf[i]) fill_buf[i] = fill_px;
      end
      REQ_RELEASE: begin
        if (brake_on) begin
          pend       = 1'b1;
          brake_on   = 1'b0;
          brake_stop = now + RELEASE_MS;
        end
      end
      REQ_REAR: begin
        rear_on = 1'b1;
        fill_px = {r_rbright, r_rlevel, fill_px[15:0]};
        for (int i = 0; i < REAR_SPLIT && i < LED_COUNT; i++) fill_buf[i] = fill_px;
        fill_px = {r_rbright, r_rlevel, r_rlevel, r_rlevel};
        for (int i = REAR_SPLIT; i < LED_COUNT; i++) fill_buf[i] = fill_px;
        refresh_at = now;
        emit_frame(1'b0, LEVEL_REAR);
      end
      default: ;
    endcase
  endtask

  // Offer one event beat, wait for the handshake, then queue its pixels.
  task automatic send_req(input logic [2:0] req, input logic [31:0] now, input int idle,
                          input chk_t chk = CHK_MODEL, input logic [31:0] flat = 32'h0,
                          input logic [4:0] lvl = 5'd0);
    in_beat_t b;
    while (idle > 0 && $urandom_range(99) < idle) begin
      @(negedge clk);
      start <= 1'b0;
    end
    b.req_type = req;
    b.now_ms   = now;
    @(negedge clk);
    start   <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    advance_strip(b);
    case (chk)
      CHK_MODEL: foreach (frame_px[k]) due_px.push_back(frame_px[k]);
      CHK_FLAT:  for (int k = 0; k < LED_COUNT; k++) due_px.push_back(pixel_beat(k, flat, lvl));
      default: ;
    endcase
  endtask

  task automatic walk_script(input int lo, input int hi);
    for (int k = lo; k < hi; k++)
      send_req(script[k].req, script[k].now, 0, script[k].chk, script[k].flat, script[k].lvl);
  endtask

  // Drop start, wait for every pixel beat, then let the block go quiet.
  task automatic settle();
    int waited;
    waited = 0;
    @(negedge clk);
    start <= 1'b0;
    while (due_px.size() != 0 && waited < SETTLE_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write all eight registers back to back while the block is idle.
  task automatic set_regs(input logic [23:0] color, input logic [7:0] sbright,
                          input logic [15:0] dur, input logic [15:0] step,
                          input logic [15:0] pause, input logic [7:0] bbright,
                          input logic [7:0] rlevel, input logic [7:0] rbright);
    logic [23:0] vals [8];
    vals[0] = color;
    vals[1] = {16'h0, sbright};
    vals[2] = {8'h0, dur};
    vals[3] = {8'h0, step};
    vals[4] = {8'h0, pause};
    vals[5] = {16'h0, bbright};
    vals[6] = {16'h0, rlevel};
    vals[7] = {16'h0, rbright};
    for (int i = 0; i < 8; i++) begin
      @(negedge clk);
      cfg_we   <= 1'b1;
      cfg_idx  <= cfg_idx_t'(i);
      cfg_data <= vals[i];
      case (cfg_idx_t'(i))
        CFG_SWEEP_COLOR:  r_color = vals[i];
        CFG_SWEEP_BRIGHT: begin
          r_sbright = vals[i][7:0];
          pend      = 1'b1;
        end
        CFG_SWEEP_DUR:    r_dur = vals[i][15:0];
        CFG_STEP_INT:     r_step = vals[i][15:0];
        CFG_END_PAUSE:    r_pause = vals[i][15:0];
        CFG_BRAKE_BRIGHT: r_bbright = vals[i][7:0];
        CFG_REAR_LEVEL:   r_rlevel = vals[i][7:0];
        CFG_REAR_BRIGHT:  r_rbright = vals[i][7:0];
        default: ;
      endcase
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Normal-mode traffic: sweep runs, brake episodes and some noise.
  task automatic drive_traffic(input int n, input int idle);
    int          done;
    int          pick;
    logic [2:0]  req;
    logic [31:0] now;
    done = 0;
    while (done < n) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        // sweep run: start, then ticks paced mostly on the step interval
        clock_ms += $urandom_range(1, 50);
        send_req(REQ_SWEEP, clock_ms, idle);
        done++;
        repeat ($urandom_range(4, 40)) begin
          pick = $urandom_range(19);
          req  = REQ_TICK;
          if (pick < 14) begin
            clock_ms += r_step + 32'd1;
          end else if (pick < 16) begin
            clock_ms += r_step + r_pause + 32'd1;
          end else if (pick < 18) begin
            clock_ms += $urandom_range(0, r_step);
          end else if (pick == 18) begin
            clock_ms += $urandom_range(0, 30);
            req = REQ_BRAKE;
          end else begin
            clock_ms += $urandom_range(0, 30);
            req = ($urandom_range(1) != 0) ? REQ_RELEASE : REQ_SWEEP;
          end
          send_req(req, clock_ms, idle);
          done++;
        end
      end else if (pick < 85) begin
        // brake episode, with or without a release
        clock_ms += $urandom_range(1, 100);
        send_req(REQ_BRAKE, clock_ms, idle);
        done++;
        repeat ($urandom_range(1, 3)) begin
          clock_ms += $urandom_range(0, 40);
          send_req(REQ_TICK, clock_ms, idle);
          done++;
        end
        if ($urandom_range(1) != 0) begin
          clock_ms += $urandom_range(0, 3000);
          send_req(REQ_RELEASE, clock_ms, idle);
          done++;
          repeat ($urandom_range(2, 5)) begin
            clock_ms += $urandom_range(0, 150);
            send_req(REQ_TICK, clock_ms, idle);
            done++;
          end
        end else begin
          repeat ($urandom_range(2, 5)) begin
            clock_ms += $urandom_range(0, 1200);
            send_req(REQ_TICK, clock_ms, idle);
            done++;
          end
        end
      end else begin
        // noise: any code but rear mode, any time stamp
        repeat ($urandom_range(1, 3)) begin
          req = 3'($urandom_range(0, 6));
          if (req >= REQ_REAR) req = req + 3'd1;
          now = $urandom();
          send_req(req, now, idle);
          if (req <= REQ_REAR) done++;
        end
      end
    end
  endtask

  // Rear-mode traffic: refresh ticks, repeated rear mode requests and requests that only change state.
  task automatic drive_rear(input int n, input int idle);
    int          done;
    int          pick;
    logic [2:0]  req;
    done = 0;
    while (done < n) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        clock_ms += $urandom_range(0, 6000);
        send_req(REQ_TICK, clock_ms, idle);
        done++;
      end else if (pick < 75) begin
        clock_ms += $urandom_range(0, 100);
        send_req(REQ_REAR, clock_ms, idle);
        done++;
      end else if (pick < 95) begin
        clock_ms += $urandom_range(0, 100);
        req = 3'($urandom_range(REQ_SWEEP, REQ_RELEASE));
        send_req(req, clock_ms, idle);
        done++;
      end else begin
        req = 3'($urandom_range(REQ_UNK_LO, REQ_UNK_HI));
        send_req(req, $urandom(), idle);
      end
    end
  endtask

  // Check every pixel beat against the oldest prediction.
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid) begin
      if (due_px.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected pixel beat: idx %0d r %02h g %02h b %02h br %02h lvl %0d last %0b",
                   out_data.pixel_index, out_data.red, out_data.green, out_data.blue,
                   out_data.pixel_brightness, out_data.frame_level, out_data.last);
        mismatches++;
      end else begin
        want = due_px.pop_front();
        if (out_data.pixel_index !== want.pixel_index || out_data.red !== want.red ||
            out_data.green !== want.green || out_data.blue !== want.blue ||
            out_data.pixel_brightness !== want.pixel_brightness ||
            out_data.frame_level !== want.frame_level || out_data.last !== want.last) begin
          if (mismatches < MAX_REPORTS) begin
            $display("pixel beat expected: idx %0d r %02h g %02h b %02h br %02h lvl %0d last %0b",
                     want.pixel_index, want.red, want.green, want.blue,
                     want.pixel_brightness, want.frame_level, want.last);
            $display("pixel beat actual:   idx %0d r %02h g %02h b %02h br %02h lvl %0d last %0b",
                     out_data.pixel_index, out_data.red, out_data.green, out_data.blue,
                     out_data.pixel_brightness, out_data.frame_level, out_data.last);
          end
          mismatches++;
        end
      end
    end
  end

  initial begin
    // hold every input at a known value and the predictor at reset
    rst_n      = 1'b0;
    start      = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_idx    = CFG_SWEEP_COLOR;
    cfg_data   = '0;
    mismatches = 0;
    foreach (fill_buf[i]) fill_buf[i] = '0;
    foreach (sweep_buf[i]) sweep_buf[i] = '0;
    fill_px    = '0;
    sweep_idx  = '0;
    refresh_at = '0;
    brake_stop = NEVER_MS;
    sweep_t0   = '0;
    step_t     = '0;
    pend       = 1'b0;
    brake_on   = 1'b0;
    sweep_on   = 1'b0;
    rear_on    = 1'b0;
    r_color    = RST_SWEEP_COLOR;
    r_sbright  = RST_SWEEP_BRIGHT;
    r_dur      = RST_SWEEP_DUR;
    r_step     = RST_STEP_INT;
    r_pause    = RST_END_PAUSE;
    r_bbright  = RST_BRAKE_BRIGHT;
    r_rlevel   = RST_REAR_LEVEL;
    r_rbright  = RST_REAR_BRIGHT;

    // directed rows in normal mode
    script.push_back(row(REQ_TICK, 32'd0, CHK_NONE));
    script.push_back(row(REQ_UNK_LO, 32'd5, CHK_NONE));
    script.push_back(row(REQ_UNK_HI, 32'hFFFF_FFFF, CHK_NONE));
    script.push_back(row(REQ_RELEASE, 32'd100, CHK_NONE));
    script.push_back(row(REQ_TICK, 32'd101, CHK_NONE));
    script.push_back(row(REQ_BRAKE, 32'd1000, CHK_NONE));
    script.push_back(row(REQ_TICK, 32'd1001, CHK_FLAT, {RST_BRAKE_BRIGHT, 8'hFF, 16'h0},
                         LEVEL_NORMAL));
    script.push_back(row(REQ_TICK, 32'd1002, CHK_NONE));
    script.push_back(row(REQ_RELEASE, 32'd2000, CHK_NONE));
    script.push_back(row(REQ_TICK, 32'd2001, CHK_MODEL));
    script.push_back(row(REQ_TICK, 32'd2251, CHK_FLAT, 32'h0, LEVEL_NORMAL));
    // brake at the top of the time range: its deadline wraps past zero
    script.push_back(row(REQ_BRAKE, 32'hFFFF_FFFF, CHK_NONE));
    script.push_back(row(REQ_TICK, 32'hFFFF_FFFF, CHK_MODEL));
    script.push_back(row(REQ_SWEEP, 32'd10000, CHK_NONE));
    script.push_back(row(REQ_SWEEP, 32'd10005, CHK_NONE));
    script.push_back(row(REQ_TICK, 32'd10020, CHK_MODEL));
    script.push_back(row(REQ_TICK, 32'd10021, CHK_MODEL));
    script.push_back(row(REQ_BRAKE, 32'd10050, CHK_MODEL));
    script.push_back(row(REQ_TICK, 32'd10063, CHK_MODEL));
    // sweep runs out on the same tick that takes a step
    script.push_back(row(REQ_TICK, 32'd13001, CHK_MODEL));
    script.push_back(row(REQ_TICK, 32'd13002, CHK_MODEL));
    // directed rows in rear mode, walked at the end since it is never left
    rear_from = script.size();
    script.push_back(row(REQ_REAR, 32'd20000, CHK_MODEL));
    script.push_back(row(REQ_TICK, 32'd20001, CHK_NONE));
    script.push_back(row(REQ_TICK, 32'd25001, CHK_MODEL));
    script.push_back(row(REQ_BRAKE, 32'd25002, CHK_MODEL));
    script.push_back(row(REQ_TICK, 32'd30003, CHK_MODEL));

    // reset once
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    walk_script(0, rear_from);
    settle();

    // upper extremes but zero step interval and end pause, no idling
    clock_ms = 32'd40000;
    set_regs(24'hFF_FFFF, 8'hFF, 16'hFFFF, 16'h0, 16'h0, 8'hFF, 8'hFF, 8'hFF);
    drive_traffic(45, 0);
    settle();

    // lower extremes but full step interval and end pause, sender mostly idle
    set_regs(24'h0, 8'h0, 16'h0, 16'hFFFF, 16'hFFFF, 8'h0, 8'h0, 8'h0);
    drive_traffic(30, 54);
    settle();

    // random setting, time stamps crossing the wrap
    clock_ms = 32'hFFFF_F000;
    set_regs(24'($urandom()), 8'($urandom()), 16'($urandom_range(800, 65535)),
             16'($urandom_range(0, 60)), 16'($urandom_range(0, 2000)), 8'($urandom()),
             8'($urandom()), 8'($urandom()));
    drive_traffic(40, 16);
    settle();

    // rear mode, dark red and full brightness
    set_regs(24'($urandom()), 8'($urandom()), 16'($urandom()), 16'($urandom_range(0, 60)),
             16'($urandom()), 8'($urandom()), 8'h0, 8'hFF);
    walk_script(rear_from, script.size());
    drive_rear(22, 54);
    settle();

    // rear mode, full red and zero brightness
    set_regs(24'($urandom()), 8'($urandom()), 16'($urandom()), 16'($urandom_range(0, 60)),
             16'($urandom()), 8'($urandom()), 8'hFF, 8'h0);
    drive_rear(20, 16);
    settle();

    if (mismatches == 0 && due_px.size() == 0) begin
      $display("led_strip_turn_brake_sequencer: match");
    end else begin
      $display("led_strip_turn_brake_sequencer: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/lsbs_pkg.sv
sv/lsbs_ctrl.sv
sv/lsbs_dpath.sv
sv/led_strip_turn_brake_sequencer.sv
sim/testbench.sv
